FILE: rtl/teq_pkg.sv
// ----------------------------------------------------------------------------
// teq_pkg: shared types and codes of the timer event queue
// command and status codes, slot table word layout and the scan unit's
// control and status bundles
// ----------------------------------------------------------------------------
package teq_pkg;

    // command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_FETCH  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NONE = 2'd2;

    localparam int unsigned TIME_BITS  = 64;
    localparam int unsigned ORDER_BITS = 32;

    // what the scan unit looks for during one sweep of the table
    typedef enum logic [1:0] {
        SCAN_FREE   = 2'd0,
        SCAN_MIN    = 2'd1,
        SCAN_MEMBER = 2'd2
    } t_scan_mode;

    // one slot table word, thread id kept in a separate array
    typedef struct packed {
        logic                  valid;
        logic [ORDER_BITS-1:0] order;
        logic [TIME_BITS-1:0]  deadline;
    } t_slot_word;

    // sequencer to scan unit
    typedef struct packed {
        logic                  clear;
        logic                  eval;
        t_scan_mode            mode;
        logic                  excl_en;
        logic [TIME_BITS-1:0]  group_deadline;
        logic [ORDER_BITS-1:0] order_now;
        logic [ORDER_BITS-1:0] span;
    } t_scan_ctl;

    // scan unit to sequencer
    typedef struct packed {
        logic                 found;
        logic [1:0]           member_cnt;
        logic                 excl_valid;
        logic [TIME_BITS-1:0] best_deadline;
    } t_scan_res;

endpackage

FILE: rtl/teq_scan_unit.sv
// ----------------------------------------------------------------------------
// teq_scan_unit: shared compare unit of the timer event queue
// takes one slot word per cycle and keeps the running result of a sweep:
// first free slot, earliest deadline, or oldest member of the due group
// ----------------------------------------------------------------------------
module teq_scan_unit #(
    parameter int unsigned SLOT_BITS   = 6,
    parameter int unsigned THREAD_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  teq_pkg::t_scan_ctl       i_ctl,
    input  teq_pkg::t_slot_word      i_word,
    input  logic [THREAD_BITS-1:0]   i_thread,
    input  logic [SLOT_BITS-1:0]     i_idx,
    input  logic [SLOT_BITS-1:0]     i_excl_idx,
    output teq_pkg::t_scan_res       o_res,
    output logic [SLOT_BITS-1:0]     o_best_idx,
    output logic [THREAD_BITS-1:0]   o_best_thread
);
    import teq_pkg::*;

    logic                   r_found;
    logic [1:0]             r_member_cnt;
    logic                   r_excl_valid;
    logic [TIME_BITS-1:0]   r_best_deadline;
    logic [ORDER_BITS-1:0]  r_best_age;
    logic [SLOT_BITS-1:0]   r_best_idx;
    logic [THREAD_BITS-1:0] r_best_thread;

    logic [ORDER_BITS-1:0]  w_age;
    logic                   w_is_member;
    logic                   w_is_excl;

    // age of the entry and group membership test
    assign w_age       = i_ctl.order_now - i_word.order;
    assign w_is_member = i_word.valid && (i_word.deadline == i_ctl.group_deadline) &&
                         (w_age > i_ctl.span);
    assign w_is_excl   = i_ctl.excl_en && (i_idx == i_excl_idx);

    // running sweep result, control part
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_found      <= 1'b0;
            r_member_cnt <= 2'd0;
            r_excl_valid <= 1'b0;
        end else if (i_ctl.eval) begin
            case (i_ctl.mode)
                SCAN_FREE: begin
                    if (!i_word.valid) begin
                        r_found <= 1'b1;
                    end
                end
                SCAN_MIN: begin
                    if (i_word.valid) begin
                        r_found <= 1'b1;
                    end
                end
                SCAN_MEMBER: begin
                    if (w_is_excl) begin
                        r_excl_valid <= i_word.valid;
                    end else if (w_is_member) begin
                        r_found <= 1'b1;
                        if (!r_member_cnt[1]) begin
                            r_member_cnt <= r_member_cnt + 2'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // running sweep result, best candidate
    always_ff @(posedge i_clk) begin
        if (i_ctl.eval) begin
            case (i_ctl.mode)
                SCAN_FREE: begin
                    if (!i_word.valid && !r_found) begin
                        r_best_idx <= i_idx;
                    end
                end
                SCAN_MIN: begin
                    if (i_word.valid && (!r_found || i_word.deadline < r_best_deadline)) begin
                        r_best_deadline <= i_word.deadline;
                    end
                end
                SCAN_MEMBER: begin
                    if (!w_is_excl && w_is_member && (!r_found || w_age > r_best_age)) begin
                        r_best_age    <= w_age;
                        r_best_idx    <= i_idx;
                        r_best_thread <= i_thread;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_res.found         = r_found;
    assign o_res.member_cnt    = r_member_cnt;
    assign o_res.excl_valid    = r_excl_valid;
    assign o_res.best_deadline = r_best_deadline;
    assign o_best_idx          = r_best_idx;
    assign o_best_thread       = r_best_thread;

endmodule

FILE: rtl/timer_event_queue_unit.sv
// ----------------------------------------------------------------------------
// timer_event_queue_unit: bounded deadline queue of timed thread events
// work per word: insert and cancel take at most one table sweep, fetch one sweep with a
//   group open and up to two when a new group has to be opened
// throughput: one word at a time, the next taken in the cycle after the result
//   word is registered, set by the sweep of the slot table through its single
//   read port and the shared compare unit, one slot per cycle
// reset: synchronous; a clearing pass over the slot table marks every slot free
//   before the first word is taken
// ----------------------------------------------------------------------------
module timer_event_queue_unit #(
    parameter int unsigned SLOTS          = 64,
    parameter int unsigned THREAD_ID_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request side
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [63:0] i_event_time,
    input  logic [15:0] i_thread_id,
    input  logic [5:0]  i_cancel_handle,
    input  logic [63:0] i_now_time,
    // result side
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [5:0]  o_new_handle,
    output logic [15:0] o_fetched_thread,
    output logic        o_pending_valid,
    output logic [63:0] o_pending_time
);
    import teq_pkg::*;

    localparam int unsigned SB = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned AW = SB + 1;
    localparam int unsigned TW = (THREAD_ID_BITS < 16) ? THREAD_ID_BITS : 16;
    localparam logic [AW-1:0] ADDR_END  = AW'(SLOTS);
    localparam logic [AW-1:0] ADDR_LAST = AW'(SLOTS - 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_WRITE = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    // slot table
    t_slot_word             r_mem_word   [SLOTS];
    logic [TW-1:0]          r_mem_thread [SLOTS];
    t_slot_word             r_rd_word;
    logic [TW-1:0]          r_rd_thread;

    // sequencer
    t_state                 r_state;
    t_scan_mode             r_mode;
    logic [AW-1:0]          r_addr;
    logic                   r_rd_vld;
    logic [SB-1:0]          r_rd_idx;
    logic                   r_scan_clr;
    logic [SB-1:0]          r_wr_idx;

    // captured request word
    logic [1:0]             r_cmd;
    logic [TIME_BITS-1:0]   r_event_time;
    logic [TW-1:0]          r_thread_in;
    logic [SB-1:0]          r_cancel_idx;
    logic [TIME_BITS-1:0]   r_now_time;

    // queue state
    logic [ORDER_BITS-1:0]  r_order_cnt;
    logic                   r_grp_active;
    logic [TIME_BITS-1:0]   r_grp_deadline;
    logic [ORDER_BITS-1:0]  r_grp_limit;
    logic [ORDER_BITS-1:0]  r_span;

    // result under construction
    logic [1:0]             r_status;
    logic [5:0]             r_handle;
    logic [15:0]            r_fthread;

    // result register
    logic                   r_out_valid;
    logic [1:0]             r_out_status;
    logic [5:0]             r_out_handle;
    logic [15:0]            r_out_fthread;
    logic                   r_out_pvalid;
    logic [63:0]            r_out_ptime;

    // write port
    logic                   w_we;
    logic                   w_thr_we;
    logic [SB-1:0]          w_waddr;
    t_slot_word             w_wdata;

    logic                   w_accept;
    logic                   w_scan_done;
    logic                   w_out_free;
    t_scan_ctl              w_ctl;
    t_scan_res              w_res;
    logic [SB-1:0]          w_best_idx;
    logic [TW-1:0]          w_best_thread;

    assign w_accept    = i_valid && !o_stall;
    assign w_scan_done = (r_addr == ADDR_END) && !r_rd_vld && !r_scan_clr;
    assign w_out_free  = !r_out_valid || !i_stall;

    // write port selection: clearing pass or the write step of a command
    always_comb begin
        w_we     = 1'b0;
        w_thr_we = 1'b0;
        w_waddr  = r_wr_idx;
        w_wdata  = '0;
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_addr[SB-1:0];
            end
            S_WRITE: begin
                w_we = 1'b1;
                if (r_cmd == CMD_INSERT) begin
                    w_thr_we         = 1'b1;
                    w_wdata.valid    = 1'b1;
                    w_wdata.order    = r_order_cnt;
                    w_wdata.deadline = r_event_time;
                end
            end
            default: begin
            end
        endcase
    end

    // slot table memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem_word[w_waddr] <= w_wdata;
        end
        if (w_thr_we) begin
            r_mem_thread[w_waddr] <= r_thread_in;
        end
        r_rd_word   <= r_mem_word[r_addr[SB-1:0]];
        r_rd_thread <= r_mem_thread[r_addr[SB-1:0]];
    end

    // shared compare unit
    assign w_ctl.clear          = r_scan_clr;
    assign w_ctl.eval           = r_rd_vld;
    assign w_ctl.mode           = r_mode;
    assign w_ctl.excl_en        = (r_cmd == CMD_CANCEL);
    assign w_ctl.group_deadline = r_grp_deadline;
    assign w_ctl.order_now      = r_order_cnt;
    assign w_ctl.span           = r_span;

    teq_scan_unit #(
        .SLOT_BITS   (SB),
        .THREAD_BITS (TW)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_word        (r_rd_word),
        .i_thread      (r_rd_thread),
        .i_idx         (r_rd_idx),
        .i_excl_idx    (r_cancel_idx),
        .o_res         (w_res),
        .o_best_idx    (w_best_idx),
        .o_best_thread (w_best_thread)
    );

    // captured request word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd        <= i_command;
            r_event_time <= i_event_time;
            r_thread_in  <= i_thread_id[TW-1:0];
            r_cancel_idx <= SB'(i_cancel_handle);
            r_now_time   <= i_now_time;
        end
    end

    // sequencer: table sweeps, queue state update and result assembly
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_mode       <= SCAN_FREE;
            r_addr       <= '0;
            r_rd_vld     <= 1'b0;
            r_scan_clr   <= 1'b0;
            r_order_cnt  <= '0;
            r_grp_active <= 1'b0;
            r_grp_deadline <= '0;
            r_grp_limit  <= '0;
            r_span       <= '0;
        end else begin
            r_scan_clr <= 1'b0;
            case (r_state)
                // mark every slot free
                S_CLEAR: begin
                    if (r_addr == ADDR_LAST) begin
                        r_addr  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                // take a word and pick the first sweep, or go straight to done for a bad handle or an unknown command
                S_IDLE: begin
                    if (w_accept) begin
                        r_status   <= ST_NONE;
                        r_handle   <= '0;
                        r_fthread  <= '0;
                        r_addr     <= '0;
                        r_rd_vld   <= 1'b0;
                        r_scan_clr <= 1'b1;
                        r_span     <= r_order_cnt - r_grp_limit;
                        r_state    <= S_SCAN;
                        case (i_command)
                            CMD_INSERT: begin
                                r_mode <= SCAN_FREE;
                            end
                            CMD_CANCEL: begin
                                r_mode <= SCAN_MEMBER;
                                if (32'(i_cancel_handle) >= SLOTS) begin
                                    r_state <= S_DONE;
                                end
                            end
                            CMD_FETCH: begin
                                r_mode <= r_grp_active ? SCAN_MEMBER : SCAN_MIN;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                // one slot read issued per cycle, then act on the sweep result
                S_SCAN: begin
                    if (r_addr != ADDR_END) begin
                        r_addr   <= r_addr + AW'(1);
                        r_rd_vld <= 1'b1;
                        r_rd_idx <= r_addr[SB-1:0];
                    end else begin
                        r_rd_vld <= 1'b0;
                    end
                    if (w_scan_done) begin
                        case (r_mode)
                            SCAN_FREE: begin
                                if (w_res.found) begin
                                    r_wr_idx <= w_best_idx;
                                    r_status <= ST_OK;
                                    r_handle <= 6'(w_best_idx);
                                    r_state  <= S_WRITE;
                                end else begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_DONE;
                                end
                            end
                            SCAN_MIN: begin
                                if (w_res.found && (w_res.best_deadline <= r_now_time)) begin
                                    r_grp_active   <= 1'b1;
                                    r_grp_deadline <= w_res.best_deadline;
                                    r_grp_limit    <= r_order_cnt;
                                    r_span         <= '0;
                                    r_mode         <= SCAN_MEMBER;
                                    r_addr         <= '0;
                                    r_scan_clr     <= 1'b1;
                                end else begin
                                    r_state <= S_DONE;
                                end
                            end
                            SCAN_MEMBER: begin
                                if (r_cmd == CMD_CANCEL) begin
                                    if (w_res.excl_valid) begin
                                        r_wr_idx <= r_cancel_idx;
                                        r_status <= ST_OK;
                                        r_state  <= S_WRITE;
                                        if (w_res.member_cnt == 2'd0) begin
                                            r_grp_active <= 1'b0;
                                        end
                                    end else begin
                                        r_state <= S_DONE;
                                    end
                                end else if (w_res.found) begin
                                    // hand out the oldest member, close if it was the last
                                    r_wr_idx     <= w_best_idx;
                                    r_fthread    <= 16'(w_best_thread);
                                    r_status     <= ST_OK;
                                    r_grp_active <= w_res.member_cnt[1];
                                    r_state      <= S_WRITE;
                                end else begin
                                    r_grp_active <= 1'b0;
                                    r_state      <= S_DONE;
                                end
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                // single table write, insert advances the order count
                S_WRITE: begin
                    if (r_cmd == CMD_INSERT) begin
                        r_order_cnt <= r_order_cnt + ORDER_BITS'(1);
                    end
                    r_state <= S_DONE;
                end
                // hand the result word to the output register
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_status  <= r_status;
            r_out_handle  <= r_handle;
            r_out_fthread <= r_fthread;
            r_out_pvalid  <= r_grp_active;
            r_out_ptime   <= r_grp_active ? r_grp_deadline : '0;
        end
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_new_handle     = r_out_handle;
    assign o_fetched_thread = r_out_fthread;
    assign o_pending_valid  = r_out_pvalid;
    assign o_pending_time   = r_out_ptime;

    // no table write may land in the middle of a sweep
    a_no_write_in_scan: assert property (@(posedge i_clk)
        i_rst_n && (r_state == S_SCAN) |-> !w_we)
        else $error("slot table written during a sweep");

    // the write step always moves straight on to the done step
    a_write_one_cycle: assert property (@(posedge i_clk)
        i_rst_n && (r_state == S_WRITE) |=> (r_state == S_DONE))
        else $error("write step did not end in one cycle");

    // order count only moves on the write step of an insert
    a_order_stable: assert property (@(posedge i_clk)
        i_rst_n && !((r_state == S_WRITE) && (r_cmd == CMD_INSERT)) |=> $stable(r_order_cnt))
        else $error("order count changed outside an insert");

    // an accepted word always starts work
    a_accept_starts: assert property (@(posedge i_clk)
        i_rst_n && w_accept |=> (r_state == S_SCAN) || (r_state == S_DONE))
        else $error("accepted word left the sequencer idle");

    // a nonzero fetched thread is only reported with an OK status
    a_thread_with_ok: assert property (@(posedge i_clk)
        i_rst_n && (r_state == S_DONE) && (r_fthread != 16'd0) |-> (r_status == ST_OK))
        else $error("fetched thread reported without done status");

endmodule
